[hdl/tdf_pkg.sv]
package tdf_pkg;

  localparam int WORD_W = 32;

  localparam logic signed [WORD_W-1:0] S32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [WORD_W-1:0] S32_MIN = 32'sh8000_0000;

  // sequencer of the top level
  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL1_GO,
    S_MUL1_WAIT,
    S_GAM,
    S_MUL2_GO,
    S_MUL2_WAIT,
    S_DEN,
    S_ABS,
    S_DIV_GO,
    S_DIV_WAIT,
    S_FINISH
  } ctl_state_t;

  typedef enum logic [1:0] {
    MUL_IDLE,
    MUL_RUN,
    MUL_FIX
  } mul_state_t;

  typedef enum logic {
    DIV_IDLE,
    DIV_RUN
  } div_state_t;

endpackage

[hdl/tdf_serial_mul.sv]
// Signed 32x32 multiply, one multiplier bit per cycle on magnitudes,
// sign applied in a final cycle.
module tdf_serial_mul (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  input  logic signed [tdf_pkg::WORD_W-1:0]     a,
  input  logic signed [tdf_pkg::WORD_W-1:0]     b,
  output logic                                  done,
  output logic signed [2*tdf_pkg::WORD_W-1:0]   product
);

  localparam int W  = tdf_pkg::WORD_W;
  localparam int CW = $clog2(W);

  tdf_pkg::mul_state_t state, state_next;

  logic [CW-1:0]  count;
  logic [W-1:0]   mcand;
  logic [W-1:0]   mplier;
  logic [2*W-1:0] acc;
  logic           neg;
  logic [W-1:0]   ua;
  logic [W-1:0]   ub;
  logic [W:0]     sum;
  logic           step_en;
  logic           fix_en;
  logic           last;

  assign ua   = a[W-1] ? (~a + 1'b1) : a;
  assign ub   = b[W-1] ? (~b + 1'b1) : b;
  assign sum  = {1'b0, acc[2*W-1:W]} + {1'b0, (mplier[0] ? mcand : {W{1'b0}})};
  assign last = (count == CW'(W - 1));

  always_comb begin
    state_next = state;
    case (state)
      tdf_pkg::MUL_IDLE: if (start) state_next = tdf_pkg::MUL_RUN;
      tdf_pkg::MUL_RUN:  if (last) state_next = tdf_pkg::MUL_FIX;
      tdf_pkg::MUL_FIX:  state_next = tdf_pkg::MUL_IDLE;
      default:           state_next = tdf_pkg::MUL_IDLE;
    endcase
  end

  always_comb begin
    step_en = 1'b0;
    fix_en  = 1'b0;
    case (state)
      tdf_pkg::MUL_RUN: step_en = 1'b1;
      tdf_pkg::MUL_FIX: fix_en  = 1'b1;
      default: begin
        step_en = 1'b0;
        fix_en  = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tdf_pkg::MUL_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= fix_en;
    end
  end

  always_ff @(posedge clk) begin
    if (state == tdf_pkg::MUL_IDLE && start) begin
      mcand  <= ua;
      mplier <= ub;
      neg    <= a[W-1] ^ b[W-1];
      acc    <= '0;
      count  <= '0;
    end
    if (step_en) begin
      acc    <= {sum, acc[W-1:1]};
      mplier <= mplier >> 1;
      count  <= count + 1'b1;
    end
    if (fix_en) begin
      product <= neg ? -$signed(acc) : $signed(acc);
    end
  end

endmodule

[hdl/tdf_serial_div.sv]
// Restoring divide of 2^(2*FRAC_BITS) by an unsigned divisor,
// one quotient bit per cycle.
module tdf_serial_div #(
  parameter int FRAC_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [2*FRAC_BITS:0]   divisor,
  output logic                   done,
  output logic [2*FRAC_BITS:0]   quot
);

  localparam int N  = 2 * FRAC_BITS + 1;
  localparam int CW = $clog2(N);

  tdf_pkg::div_state_t state, state_next;

  logic [CW-1:0] count;
  logic [N-1:0]  rem;
  logic [N-1:0]  dvd;
  logic [N-1:0]  dvs;
  logic [N:0]    trial;
  logic [N:0]    diff;
  logic          ge;
  logic          last;
  logic          step_en;

  assign trial = {rem, dvd[N-1]};
  assign diff  = trial - {1'b0, dvs};
  assign ge    = (trial >= {1'b0, dvs});
  assign last  = (count == CW'(N - 1));

  always_comb begin
    state_next = state;
    case (state)
      tdf_pkg::DIV_IDLE: if (start) state_next = tdf_pkg::DIV_RUN;
      tdf_pkg::DIV_RUN:  if (last) state_next = tdf_pkg::DIV_IDLE;
      default:           state_next = tdf_pkg::DIV_IDLE;
    endcase
  end

  always_comb begin
    case (state)
      tdf_pkg::DIV_RUN: step_en = 1'b1;
      default:          step_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tdf_pkg::DIV_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= step_en && last;
    end
  end

  always_ff @(posedge clk) begin
    if (state == tdf_pkg::DIV_IDLE && start) begin
      rem   <= '0;
      dvd   <= {1'b1, {(N-1){1'b0}}};
      dvs   <= divisor;
      count <= '0;
    end
    if (step_en) begin
      // remainder stays below the divisor, so N bits hold it
      rem   <= ge ? diff[N-1:0] : trial[N-1:0];
      quot  <= {quot[N-2:0], ge};
      dvd   <= dvd << 1;
      count <= count + 1'b1;
    end
  end

endmodule

[hdl/tridiagonal_forward_factor.sv]
// Channel  | Handshake            | Word
// ---------+----------------------+------------------------------------------------
// in       | in_valid / in_ready  | row_start, raw_diag, diag_offset, lower_coef,
//          |                      | upper_coef
// out      | out_valid / out_ready| adjusted_diag, gamma_term, pivot_recip,
//          |                      | divide_fault
//
// One word at a time: from accept to out_valid a word goes through two multiplier passes
// (gamma, then lower * gamma), the denominator and its magnitude, then the divider.
// A zero or large pivot skips the divider. in_ready returns in the cycle after the
// result is loaded.
// Reset (rst, synchronous) clears the sequencers, out_valid and the kept upper and recip.
// A stalled result holds in the output register; the next word is taken meanwhile.
module tridiagonal_forward_factor #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                row_start,
  input  logic signed [tdf_pkg::WORD_W-1:0]   raw_diag,
  input  logic signed [tdf_pkg::WORD_W-1:0]   diag_offset,
  input  logic signed [tdf_pkg::WORD_W-1:0]   lower_coef,
  input  logic signed [tdf_pkg::WORD_W-1:0]   upper_coef,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [tdf_pkg::WORD_W-1:0]   adjusted_diag,
  output logic signed [tdf_pkg::WORD_W-1:0]   gamma_term,
  output logic signed [tdf_pkg::WORD_W-1:0]   pivot_recip,
  output logic                                divide_fault
);

  localparam int W = tdf_pkg::WORD_W;
  localparam int N = 2 * FRAC_BITS + 1;   // dividend / quotient width

  tdf_pkg::ctl_state_t state, state_next;

  // word latched at accept
  logic                 start_q;
  logic signed [W-1:0]  lower_q;
  logic signed [W-1:0]  upper_q;
  logic signed [W-1:0]  adj_q;

  // intermediate results
  logic signed [W-1:0]   gam_q;
  logic signed [2*W-1:0] den_q;
  logic [2*W-1:0]        mag_q;
  logic                  den_neg;
  logic                  fault_q;
  logic                  skip_q;

  // kept between words
  logic signed [W-1:0]  prev_upper;
  logic signed [W-1:0]  prev_recip;

  // datapath wires
  logic [W:0]            adj_sum;
  logic signed [W-1:0]   adj_sat;
  logic signed [2*W-1:0] prod_sh;
  logic                  prod_fits;
  logic                  big;
  logic [N-1:0]          q;
  logic [2*W-1:0]        q64;
  logic                  ovf_pos;
  logic                  ovf_neg;
  logic signed [W-1:0]   rec;
  logic                  accept;
  logic                  slot_free;

  // unit handshakes
  logic                  mul_start;
  logic signed [W-1:0]   mul_a;
  logic signed [W-1:0]   mul_b;
  logic                  mul_done;
  logic signed [2*W-1:0] mul_product;
  logic                  div_start;
  logic                  div_done;
  logic [N-1:0]          div_quot;
  logic                  load;

  tdf_serial_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .a       (mul_a),
    .b       (mul_b),
    .done    (mul_done),
    .product (mul_product)
  );

  tdf_serial_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .divisor (mag_q[N-1:0]),
    .done    (div_done),
    .quot    (div_quot)
  );

  assign accept    = in_valid && in_ready;
  assign slot_free = !out_valid || out_ready;

  // saturating diagonal sum
  assign adj_sum = {raw_diag[W-1], raw_diag} + {diag_offset[W-1], diag_offset};
  assign adj_sat = (adj_sum[W] != adj_sum[W-1])
                   ? (adj_sum[W] ? tdf_pkg::S32_MIN : tdf_pkg::S32_MAX)
                   : adj_sum[W-1:0];

  // product back to FRAC_BITS fraction bits, floor by arithmetic shift
  assign prod_sh   = mul_product >>> FRAC_BITS;
  assign prod_fits = (&prod_sh[2*W-1:W-1]) || !(|prod_sh[2*W-1:W-1]);

  // multiplier operands: gamma pass (zero at a row start), then lower * gamma
  assign mul_a = (state == tdf_pkg::S_MUL2_GO) ? lower_q
               : (start_q ? '0 : prev_upper);
  assign mul_b = (state == tdf_pkg::S_MUL2_GO) ? gam_q : prev_recip;

  // |den| above 2^(2F) gives a zero quotient
  assign big = (|mag_q[2*W-1:N]) || (mag_q[N-1] && (|mag_q[N-2:0]));

  // reciprocal with sign and saturation
  assign q       = skip_q ? '0 : div_quot;
  assign q64     = (2*W)'(q);
  assign ovf_pos = |q64[2*W-1:W-1];
  assign ovf_neg = (|q64[2*W-1:W]) || (q64[W-1] && (|q64[W-2:0]));
  always_comb begin
    if (fault_q) begin
      rec = tdf_pkg::S32_MAX;
    end else if (!den_neg) begin
      rec = ovf_pos ? tdf_pkg::S32_MAX : $signed(q64[W-1:0]);
    end else begin
      rec = ovf_neg ? tdf_pkg::S32_MIN : -$signed(q64[W-1:0]);
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      tdf_pkg::S_IDLE:      if (in_valid) state_next = tdf_pkg::S_MUL1_GO;
      tdf_pkg::S_MUL1_GO:   state_next = tdf_pkg::S_MUL1_WAIT;
      tdf_pkg::S_MUL1_WAIT: if (mul_done) state_next = tdf_pkg::S_GAM;
      tdf_pkg::S_GAM:       state_next = tdf_pkg::S_MUL2_GO;
      tdf_pkg::S_MUL2_GO:   state_next = tdf_pkg::S_MUL2_WAIT;
      tdf_pkg::S_MUL2_WAIT: if (mul_done) state_next = tdf_pkg::S_DEN;
      tdf_pkg::S_DEN:       state_next = tdf_pkg::S_ABS;
      tdf_pkg::S_ABS:       state_next = tdf_pkg::S_DIV_GO;
      tdf_pkg::S_DIV_GO: begin
        if (big || fault_q) state_next = tdf_pkg::S_FINISH;
        else                state_next = tdf_pkg::S_DIV_WAIT;
      end
      tdf_pkg::S_DIV_WAIT:  if (div_done) state_next = tdf_pkg::S_FINISH;
      tdf_pkg::S_FINISH:    if (slot_free) state_next = tdf_pkg::S_IDLE;
      default:              state_next = tdf_pkg::S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready  = 1'b0;
    mul_start = 1'b0;
    div_start = 1'b0;
    load      = 1'b0;
    case (state)
      tdf_pkg::S_IDLE:    in_ready  = 1'b1;
      tdf_pkg::S_MUL1_GO: mul_start = 1'b1;
      tdf_pkg::S_MUL2_GO: mul_start = 1'b1;
      tdf_pkg::S_DIV_GO:  div_start = !(big || fault_q);
      tdf_pkg::S_FINISH:  load      = slot_free;
      default: begin
        in_ready  = 1'b0;
        mul_start = 1'b0;
        div_start = 1'b0;
        load      = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= tdf_pkg::S_IDLE;
      out_valid  <= 1'b0;
      prev_upper <= '0;
      prev_recip <= '0;
    end else begin
      state <= state_next;
      if (load) begin
        out_valid  <= 1'b1;
        prev_upper <= upper_q;
        prev_recip <= rec;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath registers, no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      start_q <= row_start;
      lower_q <= lower_coef;
      upper_q <= upper_coef;
      adj_q   <= adj_sat;
    end
    if (state == tdf_pkg::S_GAM) begin
      gam_q <= prod_fits ? prod_sh[W-1:0]
             : (prod_sh[2*W-1] ? tdf_pkg::S32_MIN : tdf_pkg::S32_MAX);
    end
    if (state == tdf_pkg::S_DEN) begin
      // kept wide, never saturated
      den_q <= {{W{adj_q[W-1]}}, adj_q} - prod_sh;
    end
    if (state == tdf_pkg::S_ABS) begin
      den_neg <= den_q[2*W-1];
      mag_q   <= den_q[2*W-1] ? -den_q : den_q;
      fault_q <= (den_q == '0);
    end
    if (state == tdf_pkg::S_DIV_GO) begin
      skip_q <= big || fault_q;
    end
    if (load) begin
      adjusted_diag <= adj_q;
      gamma_term    <= gam_q;
      pivot_recip   <= rec;
      divide_fault  <= fault_q;
    end
  end

endmodule

[hdl/tdf_checker.sv]
module tdf_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic signed [tdf_pkg::WORD_W-1:0]   adjusted_diag,
  input logic signed [tdf_pkg::WORD_W-1:0]   gamma_term,
  input logic signed [tdf_pkg::WORD_W-1:0]   pivot_recip,
  input logic                                divide_fault
);

  // one word in flight: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("in_ready high right after accept");

  // a zero pivot always reports the largest positive reciprocal
  a_fault_value: assert property (@(posedge clk) disable iff (rst)
    (out_valid && divide_fault) |-> (pivot_recip == tdf_pkg::S32_MAX))
    else $error("divide_fault without saturated reciprocal");

  // no result appears while a word is still being taken
  a_no_result_on_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !$rose(out_valid))
    else $error("result rose right after accept");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(adjusted_diag)
      && $stable(gamma_term) && $stable(pivot_recip) && $stable(divide_fault)))
    else $error("stalled result changed");

endmodule

bind tridiagonal_forward_factor tdf_checker u_tdf_checker (.*);

[verif/tb.sv]
`timescale 1ns / 100ps

module tb;

  localparam int WORD_W = tdf_pkg::WORD_W;
  localparam logic signed [WORD_W-1:0] S32_MAX = tdf_pkg::S32_MAX;
  localparam logic signed [WORD_W-1:0] S32_MIN = tdf_pkg::S32_MIN;

  localparam int FRAC_BITS = 16;
  localparam int RANDOM_ITEMS = 780;
  localparam int TAIL_CYCLES = 160;

  localparam logic [WORD_W-1:0] ONE     = 32'h0001_0000;
  localparam logic [WORD_W-1:0] TWO     = 32'h0002_0000;
  localparam logic [WORD_W-1:0] FOUR    = 32'h0004_0000;
  localparam logic [WORD_W-1:0] NEG_ONE = 32'hFFFF_0000;
  localparam logic [WORD_W-1:0] LSB_NEG = 32'hFFFF_FFFF;

  typedef struct packed {
    logic              row_start;
    logic [WORD_W-1:0] raw_diag;
    logic [WORD_W-1:0] diag_offset;
    logic [WORD_W-1:0] lower_coef;
    logic [WORD_W-1:0] upper_coef;
  } word_t;

  typedef struct packed {
    logic [WORD_W-1:0] adjusted;
    logic [WORD_W-1:0] gamma;
    logic [WORD_W-1:0] recip;
    logic              fault;
  } pivot_t;

  // directed row: stimulus, then a hand-typed pivot where known is set
  typedef struct packed {
    word_t  w;
    logic   known;
    pivot_t p;
  } plan_row_t;

  localparam int PLAN_LEN = 19;
  localparam plan_row_t PLAN [PLAN_LEN] = '{
    // first word after reset, no row start: gamma from cleared state
    '{'{1'b0, TWO, 32'h0, 32'h0005_0000, ONE}, 1'b1, '{TWO, 32'h0, 32'h0000_8000, 1'b0}},
    // zero pivot at a row start; lower has no effect
    '{'{1'b1, ONE, NEG_ONE, S32_MAX, ONE}, 1'b1, '{32'h0, 32'h0, S32_MAX, 1'b1}},
    // gamma built from the saturated reciprocal
    '{'{1'b0, ONE, 32'h0, 32'h0, 32'h0}, 1'b0, '0},
    // sum clamps high
    '{'{1'b1, S32_MAX, S32_MAX, 32'h0, S32_MIN}, 1'b1, '{S32_MAX, 32'h0, 32'h2, 1'b0}},
    // sum clamps low
    '{'{1'b1, S32_MIN, S32_MIN, LSB_NEG, S32_MIN}, 1'b1,
      '{S32_MIN, 32'h0, 32'hFFFF_FFFE, 1'b0}},
    // reciprocal clamps high without a fault
    '{'{1'b1, 32'h1, 32'h0, 32'h0, 32'h0}, 1'b1, '{32'h1, 32'h0, S32_MAX, 1'b0}},
    // reciprocal clamps low
    '{'{1'b1, LSB_NEG, 32'h0, 32'h0, S32_MIN}, 1'b1, '{LSB_NEG, 32'h0, S32_MIN, 1'b0}},
    // gamma clamps high (min * min)
    '{'{1'b0, 32'h0, 32'h0, S32_MAX, S32_MAX}, 1'b0, '0},
    '{'{1'b1, LSB_NEG, 32'h0, 32'h0, S32_MAX}, 1'b1, '{LSB_NEG, 32'h0, S32_MIN, 1'b0}},
    // gamma clamps low (max * min)
    '{'{1'b0, 32'h0, 32'h0, S32_MIN, 32'h0}, 1'b0, '0},
    '{'{1'b1, ONE, 32'h0, 32'h0, ONE}, 1'b1, '{ONE, 32'h0, ONE, 1'b0}},
    // zero pivot inside a row: lower * gamma cancels the diagonal
    '{'{1'b0, TWO, 32'h0, TWO, 32'h0}, 1'b1, '{TWO, ONE, S32_MAX, 1'b1}},
    '{'{1'b1, FOUR, 32'h0, S32_MAX, LSB_NEG}, 1'b1, '{FOUR, 32'h0, 32'h0000_4000, 1'b0}},
    // negative product floors toward minus infinity
    '{'{1'b0, 32'h0003_0000, 32'hFFFF_8000, 32'h1, 32'h0000_8000}, 1'b0, '0},
    '{'{1'b0, 32'h5555_5555, 32'hAAAA_AAAA, LSB_NEG, 32'hAAAA_AAAA}, 1'b0, '0},
    '{'{1'b0, 32'h0, 32'h0, 32'h0, 32'h0}, 1'b0, '0},
    '{'{1'b1, 32'hFFFD_0000, 32'h0000_8000, 32'h0001_8000, TWO}, 1'b0, '0},
    '{'{1'b0, FOUR, 32'h0, 32'h0000_4000, NEG_ONE}, 1'b0, '0},
    '{'{1'b0, 32'h0008_0000, ONE, 32'hFFFF_C000, ONE}, 1'b0, '0}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic row_start = 1'b0;
  logic signed [WORD_W-1:0] raw_diag = '0;
  logic signed [WORD_W-1:0] diag_offset = '0;
  logic signed [WORD_W-1:0] lower_coef = '0;
  logic signed [WORD_W-1:0] upper_coef = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [WORD_W-1:0] adjusted_diag;
  logic signed [WORD_W-1:0] gamma_term;
  logic signed [WORD_W-1:0] pivot_recip;
  logic divide_fault;

  int send_idle_pct = 15;
  int recv_idle_pct = 86;
  int mismatches = 0;

  // predictor state: upper and reciprocal of the last accepted word
  logic signed [WORD_W-1:0] kept_upper = '0;
  logic signed [WORD_W-1:0] kept_recip = '0;
  pivot_t pivot_q [$];

  tridiagonal_forward_factor #(
    .FRAC_BITS(FRAC_BITS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .row_start(row_start),
    .raw_diag(raw_diag),
    .diag_offset(diag_offset),
    .lower_coef(lower_coef),
    .upper_coef(upper_coef),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .adjusted_diag(adjusted_diag),
    .gamma_term(gamma_term),
    .pivot_recip(pivot_recip),
    .divide_fault(divide_fault)
  );

  always #4 clk = ~clk;

  function automatic logic [WORD_W-1:0] clamp32(input logic signed [63:0] v);
    if (v > 64'sh0000_0000_7FFF_FFFF) return S32_MAX;
    if (v < -64'sh0000_0000_8000_0000) return S32_MIN;
    return v[WORD_W-1:0];
  endfunction

  // one forward-sweep step; advances the kept upper and reciprocal
  function automatic pivot_t factor_step(input word_t w);
    pivot_t p;
    logic signed [63:0] acc;
    logic signed [63:0] den;
    acc = 64'($signed(w.raw_diag)) + 64'($signed(w.diag_offset));
    p.adjusted = clamp32(acc);
    if (w.row_start) begin
      p.gamma = '0;
    end else begin
      acc = 64'(kept_upper) * 64'(kept_recip);
      p.gamma = clamp32(acc >>> FRAC_BITS);
    end
    acc = 64'($signed(w.lower_coef)) * 64'($signed(p.gamma));
    den = 64'($signed(p.adjusted)) - (acc >>> FRAC_BITS);
    if (den == 0) begin
      p.recip = S32_MAX;
      p.fault = 1'b1;
    end else begin
      acc = (64'sd1 <<< (2 * FRAC_BITS)) / den;
      p.recip = clamp32(acc);
      p.fault = 1'b0;
    end
    kept_upper = w.upper_coef;
    kept_recip = p.recip;
    return p;
  endfunction

  function automatic logic [WORD_W-1:0] pick_value();
    logic [WORD_W-1:0] v;
    case ($urandom_range(0, 9))
      0, 1: v = $urandom;
      2: begin
        case ($urandom_range(0, 6))
          0: v = '0;
          1: v = 32'h1;
          2: v = LSB_NEG;
          3: v = S32_MAX;
          4: v = S32_MIN;
          5: v = ONE;
          default: v = NEG_ONE;
        endcase
      end
      3, 4: v = $urandom_range(0, 32'h00FF_FFFF);
      default: v = $urandom_range(0, 32'h0008_0000);
    endcase
    if ($urandom_range(0, 1)) v = -v;
    return v;
  endfunction

  task automatic flag_mismatch(input string what, input logic [WORD_W-1:0] got,
                               input logic [WORD_W-1:0] want);
    $display("mismatch %s at %0t: got %h, want %h", what, $time, got, want);
    mismatches++;
  endtask

  // present one word, hold it until taken, then queue its pivot
  task automatic send_word(input word_t w, input logic known, input pivot_t typed);
    pivot_t p;
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_valid    <= 1'b1;
    row_start   <= w.row_start;
    raw_diag    <= w.raw_diag;
    diag_offset <= w.diag_offset;
    lower_coef  <= w.lower_coef;
    upper_coef  <= w.upper_coef;
    do @(posedge clk); while (!in_ready);
    p = factor_step(w);
    pivot_q.push_back(known ? typed : p);
  endtask

  always @(posedge clk) out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);

  always @(posedge clk) begin
    pivot_t want;
    if (!rst && out_valid && out_ready) begin
      if (pivot_q.size() == 0) begin
        flag_mismatch("unexpected word", pivot_recip, 'x);
      end else begin
        want = pivot_q.pop_front();
        if (adjusted_diag !== want.adjusted)
          flag_mismatch("adjusted_diag", adjusted_diag, want.adjusted);
        if (gamma_term !== want.gamma)
          flag_mismatch("gamma_term", gamma_term, want.gamma);
        if (pivot_recip !== want.recip)
          flag_mismatch("pivot_recip", pivot_recip, want.recip);
        if (divide_fault !== want.fault)
          flag_mismatch("divide_fault", WORD_W'(divide_fault), WORD_W'(want.fault));
      end
    end
  end

  initial begin
    word_t w;
    int count;
    int len;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 15 : (phase == 1) ? 86 : 0;
      recv_idle_pct = (phase == 0) ? 86 : (phase == 1) ? 15 : 0;
      if (phase == 0) begin
        for (int i = 0; i < PLAN_LEN; i++) send_word(PLAN[i].w, PLAN[i].known, PLAN[i].p);
      end
      count = 0;
      while (count < RANDOM_ITEMS / 3) begin
        if ($urandom_range(0, 9) == 0) begin
          // noise: any flag, any bits
          w = {1'($urandom_range(0, 1)), 32'($urandom), 32'($urandom), 32'($urandom),
               32'($urandom)};
          send_word(w, 1'b0, '0);
          count++;
        end else begin
          len = $urandom_range(1, 8);
          for (int k = 0; k < len; k++) begin
            w.row_start   = (k == 0);
            w.raw_diag    = pick_value();
            w.diag_offset = ($urandom_range(0, 3) == 0) ? pick_value()
                                                        : 32'($urandom_range(0, 32'hFFFF));
            w.lower_coef  = pick_value();
            w.upper_coef  = pick_value();
            // now and then force a zero pivot, at a row start or inside a row
            if ($urandom_range(0, 15) == 0) begin
              w.diag_offset = -w.raw_diag;
              if (w.raw_diag == S32_MIN) w.raw_diag = ONE;
              w.diag_offset = -w.raw_diag;
              if (k != 0) w.lower_coef = '0;
            end
            send_word(w, 1'b0, '0);
            count++;
          end
        end
      end
    end
    in_valid <= 1'b0;
    while (pivot_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #(64'd8_000_000);
    $display("tb: failure");
    $finish;
  end

endmodule
